/* rtl/rtnp_pkg.sv */
// Package for the ringtone text note parser: field widths, character codes,
// parse phase and sequencer state types, and the note letter decode.
// No dependencies.
`timescale 1ns / 1ps

package rtnp_pkg;

   localparam int CharWidth     = 8;
   localparam int NumWidth      = 16;
   localparam int CodeWidth     = 3;
   localparam int OctWidth      = 4;
   localparam int WholeWidth    = 17;
   localparam int DurWidth      = 18;
   localparam int DivStepWidth  = $clog2(WholeWidth);

   localparam logic [CharWidth-1:0] ChNul   = 8'h00;
   localparam logic [CharWidth-1:0] ChColon = 8'h3A;
   localparam logic [CharWidth-1:0] ChComma = 8'h2C;
   localparam logic [CharWidth-1:0] ChSharp = 8'h23;
   localparam logic [CharWidth-1:0] ChDot   = 8'h2E;
   localparam logic [CharWidth-1:0] ChZero  = 8'h30;
   localparam logic [CharWidth-1:0] ChThree = 8'h33;
   localparam logic [CharWidth-1:0] ChSeven = 8'h37;
   localparam logic [CharWidth-1:0] ChNine  = 8'h39;
   localparam logic [CharWidth-1:0] ChLowD  = 8'h64;
   localparam logic [CharWidth-1:0] ChLowO  = 8'h6F;
   localparam logic [CharWidth-1:0] ChLowB  = 8'h62;
   localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
   localparam logic [CharWidth-1:0] ChUpG   = 8'h47;
   localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
   localparam logic [CharWidth-1:0] ChLowG  = 8'h67;

   localparam logic [NumWidth-1:0]   DefDivisor = 16'd4;
   localparam logic [OctWidth-1:0]   DefOctave  = 4'd6;
   localparam logic [NumWidth-1:0]   DefBpm     = 16'd63;
   localparam logic [NumWidth-1:0]   NumMax     = 16'hFFFF;
   localparam logic [WholeWidth-1:0] BeatMsX2   = 17'd30000;

   typedef enum logic [3:0] {
      PH_TITLE, PH_D_CHK, PH_D_EQ, PH_D_NUM, PH_O_CHK, PH_O_EQ, PH_O_VAL,
      PH_O_SEP, PH_B_CHK, PH_B_EQ, PH_B_NUM, PH_N_DUR, PH_N_SHARP, PH_N_DOT,
      PH_N_OCT, PH_N_END
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE, CTL_PARSE, CTL_WHOLE_DIV, CTL_NOTE_DIV, CTL_EMIT
   } ctl_type;

   function automatic logic [CodeWidth-1:0] letter_code(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] u;
      logic [CharWidth-1:0] d;
      u = c;
      if (c >= ChLowA && c <= ChLowG) u = c - 8'd32;
      d = u - ChUpA + 8'd1;
      if (u >= ChUpA && u <= ChUpG) return d[CodeWidth-1:0];
      return '0;
   endfunction

endpackage

/* rtl/rtnp_divider.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on rtnp_pkg for the operand widths.
`timescale 1ns / 1ps

module rtnp_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [rtnp_pkg::WholeWidth-1:0]   dividend,
   input  logic [rtnp_pkg::NumWidth-1:0]     divisor,
   output logic                              done,
   output logic [rtnp_pkg::WholeWidth-1:0]   quotient
);
   import rtnp_pkg::*;

   localparam logic [DivStepWidth-1:0] LastStep = DivStepWidth'(WholeWidth - 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DivStepWidth-1:0]  count_ff, count_in;
   logic [NumWidth-1:0]      rem_ff, rem_in;
   logic [NumWidth-1:0]      dsr_ff, dsr_in;
   logic [WholeWidth-1:0]    quo_ff, quo_in;
   logic [NumWidth:0]        trial;
   logic [NumWidth:0]        diff;

   assign trial = {rem_ff, quo_ff[WholeWidth-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      quo_in   = quo_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         dsr_in   = divisor;
         quo_in   = dividend;
      end else if (busy_ff) begin
         // keep the trial remainder only when the divisor fits
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = diff[NumWidth-1:0];
            quo_in = {quo_ff[WholeWidth-2:0], 1'b1};
         end else begin
            rem_in = trial[NumWidth-1:0];
            quo_in = {quo_ff[WholeWidth-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/ringtone_text_note_parser.sv */
// Ringtone text parser: byte sequencer with a shared iterative divider.
// A plain byte is accepted in CTL_IDLE, then handled in CTL_PARSE once per parse phase visited.
// Entering the note list adds the 30000/bpm divide in CTL_WHOLE_DIV; a byte
// that closes a note (',' or NUL) adds the note divide in CTL_NOTE_DIV, then CTL_EMIT.
// A new byte is taken only in CTL_IDLE, once the last one is done; CTL_EMIT waits on rsp_ready.
// Reset (synchronous): title skip, defaults d=4, o=6, b=63, no note pending.
`timescale 1ns / 1ps

module ringtone_text_note_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [rtnp_pkg::CharWidth-1:0]    req_ch,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_note_valid,
   output logic [rtnp_pkg::CodeWidth-1:0]    rsp_note_code,
   output logic                              rsp_sharp,
   output logic [rtnp_pkg::OctWidth-1:0]     rsp_octave,
   output logic [rtnp_pkg::DurWidth-1:0]     rsp_duration_ms,
   output logic                              rsp_tune_done
);
   import rtnp_pkg::*;

   ctl_type               ctl_ff, ctl_in;
   phase_type             phase_ff, phase_in;
   logic [CharWidth-1:0]  ch_ff, ch_in;
   logic                  done_ff, done_in;
   logic                  again_ff, again_in;
   logic [NumWidth-1:0]   ddiv_ff, ddiv_in;
   logic [OctWidth-1:0]   doct_ff, doct_in;
   logic [NumWidth-1:0]   bpm_ff, bpm_in;
   logic [WholeWidth-1:0] whole_ff, whole_in;
   logic [NumWidth-1:0]   acc_ff, acc_in;
   logic [CodeWidth-1:0]  plet_ff, plet_in;
   logic                  psharp_ff, psharp_in;
   logic                  pdot_ff, pdot_in;
   logic [OctWidth-1:0]   poct_ff, poct_in;
   logic                  pend_ff, pend_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_nv_ff, rsp_nv_in;
   logic [CodeWidth-1:0]  rsp_code_ff, rsp_code_in;
   logic                  rsp_sharp_ff, rsp_sharp_in;
   logic [OctWidth-1:0]   rsp_oct_ff, rsp_oct_in;
   logic [DurWidth-1:0]   rsp_dur_ff, rsp_dur_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic                  div_start;
   logic [WholeWidth-1:0] div_dividend;
   logic [NumWidth-1:0]   div_divisor;
   logic                  div_done;
   logic [WholeWidth-1:0] div_quo;

   logic                  is_digit;
   logic [NumWidth+3:0]   acc_next;
   logic [NumWidth-1:0]   acc_sat;
   logic [NumWidth-1:0]   note_div;
   logic [DurWidth-1:0]   dur;

   rtnp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign is_digit = (ch_ff >= ChZero) && (ch_ff <= ChNine);
   assign acc_next = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1)
                     + {16'b0, ch_ff[3:0]};
   assign acc_sat  = (acc_next > {4'b0, NumMax}) ? NumMax : acc_next[NumWidth-1:0];
   assign note_div = (acc_ff != '0) ? acc_ff :
                     ((ddiv_ff != '0) ? ddiv_ff : NumWidth'(1));
   assign dur      = {1'b0, div_quo} + {2'b0, div_quo[WholeWidth-1:1]};

   always_comb begin
      ctl_in    = ctl_ff;
      phase_in  = phase_ff;
      ch_in     = ch_ff;
      done_in   = done_ff;
      again_in  = again_ff;
      ddiv_in   = ddiv_ff;
      doct_in   = doct_ff;
      bpm_in    = bpm_ff;
      whole_in  = whole_ff;
      acc_in    = acc_ff;
      plet_in   = plet_ff;
      psharp_in = psharp_ff;
      pdot_in   = pdot_ff;
      poct_in   = poct_ff;
      pend_in   = pend_ff;

      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_nv_in    = rsp_nv_ff;
      rsp_code_in  = rsp_code_ff;
      rsp_sharp_in = rsp_sharp_ff;
      rsp_oct_in   = rsp_oct_ff;
      rsp_dur_in   = rsp_dur_ff;
      rsp_done_in  = rsp_done_ff;

      div_start    = 1'b0;
      div_dividend = {1'b0, acc_ff};
      div_divisor  = note_div;

      req_ready = (ctl_ff == CTL_IDLE);

      unique case (ctl_ff)
         CTL_IDLE: begin
            if (req_valid) begin
               ch_in = req_ch;
               if (req_ch == ChNul) begin
                  done_in = 1'b1;
                  if (pend_ff) begin
                     div_start    = 1'b1;
                     div_dividend = whole_ff;
                     ctl_in       = CTL_NOTE_DIV;
                  end else begin
                     ctl_in = CTL_EMIT;
                  end
               end else begin
                  done_in = 1'b0;
                  ctl_in  = CTL_PARSE;
               end
            end
         end
         CTL_PARSE: begin
            // default: byte consumed; arms that re-dispatch keep CTL_PARSE
            ctl_in = CTL_IDLE;
            unique case (phase_ff)
               PH_TITLE: if (ch_ff == ChColon) phase_in = PH_D_CHK;
               PH_D_CHK: begin
                  if (ch_ff == ChLowD) phase_in = PH_D_EQ;
                  else begin
                     phase_in = PH_O_CHK;
                     ctl_in   = CTL_PARSE;
                  end
               end
               PH_D_EQ: begin
                  acc_in   = '0;
                  phase_in = PH_D_NUM;
               end
               PH_D_NUM: begin
                  if (is_digit) acc_in = acc_sat;
                  else begin
                     if (acc_ff != '0) ddiv_in = acc_ff;
                     acc_in   = '0;
                     phase_in = PH_O_CHK;
                  end
               end
               PH_O_CHK: begin
                  if (ch_ff == ChLowO) phase_in = PH_O_EQ;
                  else begin
                     phase_in = PH_B_CHK;
                     ctl_in   = CTL_PARSE;
                  end
               end
               PH_O_EQ: phase_in = PH_O_VAL;
               PH_O_VAL: begin
                  if (ch_ff >= ChThree && ch_ff <= ChSeven) doct_in = ch_ff[3:0];
                  phase_in = PH_O_SEP;
               end
               PH_O_SEP: phase_in = PH_B_CHK;
               PH_B_CHK: begin
                  if (ch_ff == ChLowB) phase_in = PH_B_EQ;
                  else begin
                     // enter the note list, then parse this byte again
                     div_start    = 1'b1;
                     div_dividend = BeatMsX2;
                     div_divisor  = (bpm_ff != '0) ? bpm_ff : DefBpm;
                     acc_in       = '0;
                     phase_in     = PH_N_DUR;
                     again_in     = 1'b1;
                     ctl_in       = CTL_WHOLE_DIV;
                  end
               end
               PH_B_EQ: begin
                  acc_in   = '0;
                  phase_in = PH_B_NUM;
               end
               PH_B_NUM: begin
                  if (is_digit) acc_in = acc_sat;
                  else begin
                     bpm_in       = (acc_ff != '0) ? acc_ff : DefBpm;
                     div_start    = 1'b1;
                     div_dividend = BeatMsX2;
                     div_divisor  = (acc_ff != '0) ? acc_ff : DefBpm;
                     acc_in       = '0;
                     phase_in     = PH_N_DUR;
                     again_in     = 1'b0;
                     ctl_in       = CTL_WHOLE_DIV;
                  end
               end
               PH_N_DUR: begin
                  if (is_digit) acc_in = acc_sat;
                  else begin
                     plet_in  = letter_code(ch_ff);
                     pend_in  = 1'b1;
                     phase_in = PH_N_SHARP;
                  end
               end
               PH_N_SHARP: begin
                  phase_in = PH_N_DOT;
                  if (ch_ff == ChSharp) psharp_in = 1'b1;
                  else ctl_in = CTL_PARSE;
               end
               PH_N_DOT: begin
                  phase_in = PH_N_OCT;
                  if (ch_ff == ChDot) pdot_in = 1'b1;
                  else ctl_in = CTL_PARSE;
               end
               PH_N_OCT: begin
                  phase_in = PH_N_END;
                  if (is_digit) poct_in = ch_ff[3:0];
                  else ctl_in = CTL_PARSE;
               end
               PH_N_END: begin
                  if (ch_ff == ChComma) begin
                     div_start    = 1'b1;
                     div_dividend = whole_ff;
                     ctl_in       = CTL_NOTE_DIV;
                  end else begin
                     // missing comma: drop the note, reparse as a new note
                     plet_in   = '0;
                     psharp_in = 1'b0;
                     pdot_in   = 1'b0;
                     poct_in   = '0;
                     pend_in   = 1'b0;
                     acc_in    = '0;
                     phase_in  = PH_N_DUR;
                     ctl_in    = CTL_PARSE;
                  end
               end
               default: ctl_in = CTL_IDLE;
            endcase
         end
         CTL_WHOLE_DIV: begin
            if (div_done) begin
               whole_in = {div_quo[WholeWidth-3:0], 2'b00};
               ctl_in   = again_ff ? CTL_PARSE : CTL_IDLE;
            end
         end
         CTL_NOTE_DIV: begin
            if (div_done) ctl_in = CTL_EMIT;
         end
         CTL_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_nv_in    = pend_ff;
               rsp_code_in  = pend_ff ? plet_ff : '0;
               rsp_sharp_in = pend_ff & psharp_ff;
               rsp_oct_in   = !pend_ff ? '0 : ((poct_ff != '0) ? poct_ff : doct_ff);
               rsp_dur_in   = !pend_ff ? '0 : (pdot_ff ? dur : {1'b0, div_quo});
               rsp_done_in  = done_ff;
               plet_in   = '0;
               psharp_in = 1'b0;
               pdot_in   = 1'b0;
               poct_in   = '0;
               pend_in   = 1'b0;
               acc_in    = '0;
               phase_in  = PH_N_DUR;
               if (done_ff) begin
                  phase_in = PH_TITLE;
                  ddiv_in  = DefDivisor;
                  doct_in  = DefOctave;
                  bpm_in   = DefBpm;
                  whole_in = '0;
               end
               ctl_in = CTL_IDLE;
            end
         end
         default: ctl_in = CTL_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_IDLE;
         phase_ff     <= PH_TITLE;
         done_ff      <= 1'b0;
         again_ff     <= 1'b0;
         ddiv_ff      <= DefDivisor;
         doct_ff      <= DefOctave;
         bpm_ff       <= DefBpm;
         whole_ff     <= '0;
         acc_ff       <= '0;
         plet_ff      <= '0;
         psharp_ff    <= 1'b0;
         pdot_ff      <= 1'b0;
         poct_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctl_ff       <= ctl_in;
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         again_ff     <= again_in;
         ddiv_ff      <= ddiv_in;
         doct_ff      <= doct_in;
         bpm_ff       <= bpm_in;
         whole_ff     <= whole_in;
         acc_ff       <= acc_in;
         plet_ff      <= plet_in;
         psharp_ff    <= psharp_in;
         pdot_ff      <= pdot_in;
         poct_ff      <= poct_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ch_ff        <= ch_in;
      rsp_nv_ff    <= rsp_nv_in;
      rsp_code_ff  <= rsp_code_in;
      rsp_sharp_ff <= rsp_sharp_in;
      rsp_oct_ff   <= rsp_oct_in;
      rsp_dur_ff   <= rsp_dur_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_note_valid  = rsp_nv_ff;
   assign rsp_note_code   = rsp_code_ff;
   assign rsp_sharp       = rsp_sharp_ff;
   assign rsp_octave      = rsp_oct_ff;
   assign rsp_duration_ms = rsp_dur_ff;
   assign rsp_tune_done   = rsp_done_ff;

endmodule
